### sv/sed_pkg.sv
// Shared types and constants of the string escape decoder.
package sed_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_ESCAPE  = 2'd1;
   localparam logic [1:0] ERR_HEX     = 2'd2;
   localparam logic [1:0] ERR_CONTROL = 2'd3;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;
   localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_string;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [1:0] error_code;
      logic       last;
   } rsp_word_type;

   // All results caused by one input byte, handed from front to back.
   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] error_code;
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } sed_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sed_queue_status_type;

endpackage

### sv/sed_front.sv
// Front end: accepts raw bytes, tracks escape state and builds result jobs.
module sed_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sed_pkg::req_word_type         req_word,
   input  sed_pkg::sed_queue_status_type queue_status,
   output logic                          push,
   output sed_pkg::sed_job_type          job
);
   import sed_pkg::*;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_TEXT = 3'd1;
   localparam logic [2:0] MODE_ESC  = 3'd2;
   localparam logic [2:0] MODE_HEX1 = 3'd3;
   localparam logic [2:0] MODE_HEX2 = 3'd4;
   localparam logic [2:0] MODE_HEX3 = 3'd5;
   localparam logic [2:0] MODE_HEX4 = 3'd6;

   logic [2:0]  mode_ff, mode_in, cur_mode;
   logic [11:0] acc_ff, acc_in, cur_acc;
   logic [7:0]  c;
   logic        accept;
   logic        is_num, is_upper, is_lower, hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] cp;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (job.count != 2'd0);
   assign c         = req_word.in_byte;

   // A string start drops whatever was open and begins in plain text.
   assign cur_mode = req_word.first_of_string ? MODE_TEXT : mode_ff;
   assign cur_acc  = req_word.first_of_string ? 12'd0 : acc_ff;

   assign is_num    = (c >= 8'h30) && (c <= 8'h39);
   assign is_upper  = (c >= 8'h41) && (c <= 8'h46);
   assign is_lower  = (c >= 8'h61) && (c <= 8'h66);
   assign hex_ok    = is_num || is_upper || is_lower;
   assign hex_digit = is_num ? c[3:0] : c[3:0] + 4'd9;
   assign cp        = {cur_acc, hex_digit};

   always_comb begin
      mode_in        = cur_mode;
      acc_in         = cur_acc;
      job            = '0;
      job.kind       = KIND_DATA;
      job.error_code = ERR_NONE;
      case (cur_mode)
         MODE_TEXT: begin
            if (c < 8'h20) begin
               job.kind       = KIND_ERROR;
               job.error_code = ERR_CONTROL;
               job.count      = 2'd1;
               mode_in        = MODE_IDLE;
               acc_in         = 12'd0;
            end else if (c == 8'h22) begin
               job.kind  = KIND_END;
               job.count = 2'd1;
               mode_in   = MODE_IDLE;
            end else if (c == 8'h5C) begin
               mode_in = MODE_ESC;
            end else begin
               job.count = 2'd1;
               job.byte0 = c;
            end
         end
         MODE_ESC: begin
            job.count = 2'd1;
            mode_in   = MODE_TEXT;
            case (c)
               8'h22, 8'h5C, 8'h2F: job.byte0 = c;
               8'h62: job.byte0 = 8'h08;
               8'h66: job.byte0 = 8'h0C;
               8'h6E: job.byte0 = 8'h0A;
               8'h72: job.byte0 = 8'h0D;
               8'h74: job.byte0 = 8'h09;
               8'h75: begin
                  job.count = 2'd0;
                  mode_in   = MODE_HEX1;
                  acc_in    = 12'd0;
               end
               default: begin
                  job.kind       = KIND_ERROR;
                  job.error_code = ERR_ESCAPE;
                  mode_in        = MODE_IDLE;
                  acc_in         = 12'd0;
               end
            endcase
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
            if (!hex_ok) begin
               job.kind       = KIND_ERROR;
               job.error_code = ERR_HEX;
               job.count      = 2'd1;
               mode_in        = MODE_IDLE;
               acc_in         = 12'd0;
            end else if (cur_mode != MODE_HEX4) begin
               acc_in  = {cur_acc[7:0], hex_digit};
               mode_in = cur_mode + 3'd1;
            end else begin
               acc_in  = 12'd0;
               mode_in = MODE_TEXT;
               if (cp < UTF8_TWO_MIN) begin
                  job.count = 2'd1;
                  job.byte0 = cp[7:0];
               end else if (cp < UTF8_THREE_MIN) begin
                  job.count = 2'd2;
                  job.byte0 = UTF8_LEAD2 | {3'd0, cp[10:6]};
                  job.byte1 = UTF8_CONT | {2'd0, cp[5:0]};
               end else begin
                  job.count = 2'd3;
                  job.byte0 = UTF8_LEAD3 | {4'd0, cp[15:12]};
                  job.byte1 = UTF8_CONT | {2'd0, cp[11:6]};
                  job.byte2 = UTF8_CONT | {2'd0, cp[5:0]};
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= 12'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
      end
   end

   // Partial hex digits are only ever held while a unicode escape is open.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE || mode_ff == MODE_TEXT || mode_ff == MODE_ESC)
      |-> (acc_ff == 12'd0))
      else $error("hex accumulator nonzero outside a unicode escape");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HEX1) |-> (acc_ff == 12'd0))
      else $error("hex accumulator not cleared at escape start");

endmodule

### sv/sed_queue.sv
// Small job queue between the front end and the result sequencer.
module sed_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sed_pkg::sed_job_type          push_job,
   input  logic                          pop,
   output sed_pkg::sed_job_type          head_job,
   output sed_pkg::sed_queue_status_type status
);
   import sed_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sed_job_type        slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job pushed into a full queue");

endmodule

### sv/sed_back.sv
// Back end: walks each queued job and issues its results one word per cycle while rsp_ready allows.
module sed_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sed_pkg::sed_job_type          head_job,
   input  sed_pkg::sed_queue_status_type queue_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sed_pkg::rsp_word_type         rsp_word
);
   import sed_pkg::*;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic [1:0]   idx_ff;
   logic         load, final_one;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The output register refills in the same cycle it is emptied.
   assign load      = !queue_status.empty && (!rsp_valid_ff || rsp_ready);
   assign final_one = ((idx_ff + 2'd1) == head_job.count);
   assign pop       = load && final_one;

   always_comb begin
      rsp_word_in.kind       = head_job.kind;
      rsp_word_in.error_code = head_job.error_code;
      rsp_word_in.last       = final_one;
      case (idx_ff)
         2'd0:    rsp_word_in.out_byte = head_job.byte0;
         2'd1:    rsp_word_in.out_byte = head_job.byte1;
         default: rsp_word_in.out_byte = head_job.byte2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= final_one ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !queue_status.empty |-> (idx_ff < head_job.count))
      else $error("result index beyond the job's result count");

   assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> (idx_ff == 2'd0))
      else $error("result index left nonzero with no job queued");

endmodule

### sv/string_escape_decoder.sv
// Top level of the string escape decoder: front end, job queue and back end.
//
// The req channel takes one raw byte of a double-quoted string body per word,
// with first_of_string set on the byte right after the opening quote. The rsp
// channel returns decoded data bytes, an end word at the closing quote and an
// error word on a bad escape, bad hex digit or control byte; last marks the
// final word caused by an input byte. After an error, bytes are dropped until
// the next first_of_string.
// A byte is classified in the cycle it is accepted and its job is written
// into the queue; its first word then passes into the output register, so
// the earliest rsp handshake follows both registers. The front end takes a
// byte every cycle while the job queue (QUEUE_DEPTH entries) has room; the
// back end issues one word per cycle while rsp_ready is high, so the extra
// words of a unicode escape that expands to two or three UTF-8 bytes are
// absorbed by the queue, since such an escape spans six input bytes.
// Reset clears the escape state, the queue and the output valid flag. While
// rsp_ready is low the output word holds, the queue fills, and req_ready
// drops once it is full.
module string_escape_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sed_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sed_pkg::rsp_word_type rsp_word
);
   import sed_pkg::*;

   sed_job_type          push_job, head_job;
   sed_queue_status_type queue_status;
   logic                 push, pop;

   sed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .queue_status (queue_status),
      .push         (push),
      .job          (push_job)
   );

   sed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   sed_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word)
   );

endmodule
